>>> rtl/bst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants of the byte stream tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

   // default sizes
   localparam int POSITION_BITS_DEF   = 16;
   localparam int MAX_DELIM_BYTES_DEF = 8;

   // fixed field widths
   localparam int FIELD_W     = 16;
   localparam int DLEN_W      = 4;
   localparam int CSR_W       = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 4;

   // byte codes
   localparam logic [7:0] BYTE_CR    = 8'd13;
   localparam logic [7:0] BYTE_LF    = 8'd10;
   localparam logic [7:0] BYTE_SPACE = 8'd32;
   localparam logic [7:0] BYTE_HIGH  = 8'd128;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPLIT_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_LEN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_BYTES = 2'd2;

   // register reset values
   localparam logic [1:0]        SPLIT_MODE_RST  = 2'd1;
   localparam logic [DLEN_W-1:0] DELIM_LEN_RST   = 4'd1;
   localparam logic [CSR_W-1:0]  DELIM_BYTES_RST = 64'd44;

   // split modes; the unused code behaves as whitespace mode
   typedef enum logic [1:0] {
      MODE_DELIM = 2'd0,
      MODE_SPACE = 2'd1,
      MODE_LINE  = 2'd2
   } mode_type;

   // input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       no_byte;
   } req_type;

   // result word
   typedef struct packed {
      logic [FIELD_W-1:0] token_start;
      logic [FIELD_W-1:0] token_length;
      logic               is_token;
      logic               end_of_string;
      logic               length_overflow;
   } rsp_type;

   // classified word from front to back
   typedef struct packed {
      mode_type          mode;
      logic              hit;   // delimiter match, separator or line break
      logic              last;
      logic              none;
      logic [DLEN_W-1:0] dlen;
   } class_type;

endpackage

>>> rtl/bst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_front
// Accepts input words, holds the registers and the delimiter window, and
// classifies each byte for the back end.
// ----------------------------------------------------------------------------
module bst_front import bst_pkg::*; #(
   parameter int MAX_DELIM_BYTES = MAX_DELIM_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   input  logic                   q_full,
   output logic                   q_push,
   output class_type              q_word
);

   localparam int WIN_W  = 8 * MAX_DELIM_BYTES;
   localparam int FILL_W = $clog2(MAX_DELIM_BYTES + 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_DELIM_BYTES);
   localparam logic [DLEN_W-1:0] DLEN_MAX = DLEN_W'(MAX_DELIM_BYTES);

   logic [1:0]        mode_ff,  mode_in;
   logic [DLEN_W-1:0] dlen_ff,  dlen_in;
   logic [CSR_W-1:0]  delim_ff, delim_in;
   logic [WIN_W-1:0]  window_ff, window_in;
   logic [FILL_W-1:0] fill_ff,   fill_in;

   mode_type          mode;
   logic [DLEN_W-1:0] eff_len;
   logic [WIN_W-1:0]  win_shift;
   logic [FILL_W-1:0] fill_inc;
   logic              match;
   logic              accept;

   // register writes
   always_comb begin
      mode_in  = mode_ff;
      dlen_in  = dlen_ff;
      delim_in = delim_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPLIT_MODE:  mode_in  = csr_wdata[1:0];
            CSR_DELIM_LEN:   dlen_in  = csr_wdata[DLEN_W-1:0];
            CSR_DELIM_BYTES: delim_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // mode and effective delimiter length
   always_comb begin
      if (mode_ff == MODE_DELIM) begin
         mode = MODE_DELIM;
      end else if (mode_ff == MODE_LINE) begin
         mode = MODE_LINE;
      end else begin
         mode = MODE_SPACE;
      end
      if (dlen_ff == '0) begin
         eff_len = DLEN_W'(1);
      end else if (dlen_ff > DLEN_MAX) begin
         eff_len = DLEN_MAX;
      end else begin
         eff_len = dlen_ff;
      end
   end

   // window with the new byte shifted in, newest byte lowest
   assign win_shift = (window_ff << 8) | WIN_W'(req_data.data_byte);
   assign fill_inc  = (fill_ff < FILL_MAX) ? fill_ff + FILL_W'(1) : fill_ff;

   // delimiter compare: delimiter byte i against window byte len-1-i
   always_comb begin
      int idx;
      idx   = 0;
      match = (DLEN_W'(fill_inc) >= eff_len);
      for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
         if (i < int'(eff_len)) begin
            idx = int'(eff_len) - 1 - i;
            if (win_shift[8*idx +: 8] != delim_ff[8*i +: 8]) begin
               match = 1'b0;
            end
         end
      end
   end

   // classified word
   always_comb begin
      q_word.mode = mode;
      q_word.last = req_data.last_byte;
      q_word.none = req_data.no_byte;
      q_word.dlen = eff_len;
      unique case (mode)
         MODE_DELIM: q_word.hit = match;
         MODE_LINE:  q_word.hit = (req_data.data_byte == BYTE_CR) ||
                                  (req_data.data_byte == BYTE_LF);
         default:    q_word.hit = (req_data.data_byte <= BYTE_SPACE) ||
                                  (req_data.data_byte >= BYTE_HIGH);
      endcase
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   // idle words change nothing and are dropped here
   assign q_push    = accept && !(req_data.no_byte && !req_data.last_byte);

   // window update
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            window_in = '0;
            fill_in   = '0;
         end else if (!req_data.no_byte && (mode == MODE_DELIM)) begin
            if (match) begin
               window_in = '0;
               fill_in   = '0;
            end else begin
               window_in = win_shift;
               fill_in   = fill_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= SPLIT_MODE_RST;
         dlen_ff   <= DELIM_LEN_RST;
         delim_ff  <= DELIM_BYTES_RST;
         window_ff <= '0;
         fill_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         dlen_ff   <= dlen_in;
         delim_ff  <= delim_in;
         window_ff <= window_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> rtl/bst_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_fifo
// Short queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module bst_fifo import bst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  class_type push_word,
   input  logic      pop,
   output class_type head_word,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   class_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_word = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/bst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_back
// Tracks positions and open tokens, turns classified words into results
// and holds up to two results for the output channel.
// ----------------------------------------------------------------------------
module bst_back import bst_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  class_type q_word,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int P  = POSITION_BITS;
   localparam int PX = POSITION_BITS + 1;
   localparam logic [P-1:0] POS_MAX = '1;

   logic [P-1:0] pos_ff,   pos_in;
   logic [P-1:0] start_ff, start_in;
   logic         run_ff,   run_in;
   logic         ovf_ff,   ovf_in;
   logic         closed_ff, closed_in;
   rsp_type      buf_ff [2];
   rsp_type      buf_in [2];
   logic [1:0]   cnt_ff,   cnt_in;

   logic         take;
   logic [P-1:0] p_cur;
   logic [P-1:0] p_cnt;
   logic         ovf_new;
   logic [PX-1:0] ms;
   logic [PX-1:0] p_inc;
   logic [PX-1:0] len_x;
   rsp_type      r0, r1;
   logic [1:0]   n_res;

   // one result word, lengths and positions cut to the field width
   function automatic rsp_type mk(input logic [PX-1:0] start, input logic [PX-1:0] len,
                                  input logic tok, input logic eos, input logic ovf);
      rsp_type r;
      r.token_start     = FIELD_W'(start);
      r.token_length    = FIELD_W'(len);
      r.is_token        = tok;
      r.end_of_string   = eos;
      r.length_overflow = ovf;
      return r;
   endfunction

   // distance from one position to a later one, zero if not later
   function automatic logic [PX-1:0] span(input logic [PX-1:0] from, input logic [PX-1:0] to);
      logic [PX-1:0] d;
      d = (to >= from) ? to - from : '0;
      return d;
   endfunction

   assign take  = rsp_valid && rsp_ready;
   assign q_pop = !q_empty && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && take));

   // position of this byte, saturating
   always_comb begin
      p_cur = pos_ff;
      if (pos_ff >= POS_MAX) begin
         p_cur   = POS_MAX;
         p_cnt   = POS_MAX;
         ovf_new = 1'b1;
      end else begin
         p_cnt   = pos_ff + P'(1);
         ovf_new = ovf_ff;
      end
      p_inc = PX'(p_cur) + PX'(1);
      len_x = PX'(q_word.dlen);
      ms    = (p_inc >= len_x) ? p_inc - len_x : '0;
   end

   // token rules
   always_comb begin
      logic [PX-1:0] beg;
      logic [PX-1:0] lp;
      beg       = PX'(start_ff);
      lp        = ovf_ff ? PX'(POS_MAX) : PX'(pos_ff - P'(1));
      pos_in    = pos_ff;
      start_in  = start_ff;
      run_in    = run_ff;
      ovf_in    = ovf_ff;
      closed_in = closed_ff;
      r0        = mk('0, '0, 1'b0, 1'b1, ovf_ff);
      r1        = mk('0, '0, 1'b0, 1'b1, ovf_ff);
      n_res     = 2'd0;
      if (q_word.none) begin
         // end of string without a byte
         n_res = 2'd1;
         if ((pos_ff == '0) && !ovf_ff) begin
            r0 = mk('0, '0, 1'b0, 1'b1, ovf_ff);
         end else if (q_word.mode == MODE_DELIM) begin
            if (closed_ff) begin
               r0 = mk(PX'(pos_ff), '0, 1'b1, 1'b1, ovf_ff);
            end else begin
               r0 = mk(beg, span(beg, PX'(pos_ff)), 1'b1, 1'b1, ovf_ff);
            end
         end else if (run_ff) begin
            r0 = mk(beg, span(beg, PX'(pos_ff)), 1'b1, 1'b1, ovf_ff);
         end else if ((q_word.mode == MODE_LINE) && closed_ff) begin
            r0 = mk(lp, '0, 1'b1, 1'b1, ovf_ff);
         end else begin
            r0 = mk('0, '0, 1'b0, 1'b1, ovf_ff);
         end
      end else begin
         pos_in = p_cnt;
         ovf_in = ovf_new;
         unique case (q_word.mode)
            // delimiter split
            MODE_DELIM: begin
               if (q_word.hit) begin
                  r0        = mk(beg, span(beg, ms), 1'b1, 1'b0, ovf_new);
                  r1        = mk(PX'(p_cnt), '0, 1'b1, 1'b1, ovf_new);
                  n_res     = q_word.last ? 2'd2 : 2'd1;
                  start_in  = p_cnt;
                  closed_in = 1'b1;
               end else begin
                  r0        = mk(beg, span(beg, PX'(p_cnt)), 1'b1, 1'b1, ovf_new);
                  n_res     = q_word.last ? 2'd1 : 2'd0;
                  closed_in = 1'b0;
               end
            end
            // line split
            MODE_LINE: begin
               if (q_word.hit && run_ff) begin
                  r0        = mk(beg, span(beg, PX'(p_cur)), 1'b1, 1'b0, ovf_new);
                  r1        = mk(PX'(p_cur), '0, 1'b1, 1'b1, ovf_new);
                  n_res     = q_word.last ? 2'd2 : 2'd1;
                  run_in    = 1'b0;
                  closed_in = 1'b1;
               end else if (q_word.hit) begin
                  r0        = mk(PX'(p_cur), '0, 1'b1, q_word.last, ovf_new);
                  n_res     = 2'd1;
                  closed_in = 1'b0;
               end else begin
                  if (!run_ff) begin
                     beg      = PX'(p_cur);
                     start_in = p_cur;
                     run_in   = 1'b1;
                  end
                  r0        = mk(beg, span(beg, PX'(p_cnt)), 1'b1, 1'b1, ovf_new);
                  n_res     = q_word.last ? 2'd1 : 2'd0;
                  closed_in = 1'b0;
               end
            end
            // whitespace runs
            default: begin
               if (!q_word.hit) begin
                  if (!run_ff) begin
                     beg      = PX'(p_cur);
                     start_in = p_cur;
                     run_in   = 1'b1;
                  end
                  r0    = mk(beg, span(beg, PX'(p_cnt)), 1'b1, 1'b1, ovf_new);
                  n_res = q_word.last ? 2'd1 : 2'd0;
               end else if (run_ff) begin
                  r0     = mk(beg, span(beg, PX'(p_cur)), 1'b1, q_word.last, ovf_new);
                  n_res  = 2'd1;
                  run_in = 1'b0;
               end else begin
                  r0    = mk('0, '0, 1'b0, 1'b1, ovf_new);
                  n_res = q_word.last ? 2'd1 : 2'd0;
               end
            end
         endcase
      end
      // string done: back to the start state
      if (q_word.last) begin
         pos_in    = '0;
         start_in  = '0;
         run_in    = 1'b0;
         ovf_in    = 1'b0;
         closed_in = 1'b0;
      end
   end

   // output buffer, filled only when it is empty or drains empty this cycle
   always_comb begin
      buf_in[0] = buf_ff[0];
      buf_in[1] = buf_ff[1];
      cnt_in    = cnt_ff;
      if (q_pop) begin
         buf_in[0] = r0;
         buf_in[1] = r1;
         cnt_in    = n_res;
      end else if (take) begin
         buf_in[0] = buf_ff[1];
         cnt_in    = cnt_ff - 2'd1;
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = buf_ff[0];

   always_ff @(posedge clock) begin
      buf_ff[0] <= buf_in[0];
      buf_ff[1] <= buf_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         start_ff  <= '0;
         run_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         closed_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (q_pop) begin
            pos_ff    <= pos_in;
            start_ff  <= start_in;
            run_ff    <= run_in;
            ovf_ff    <= ovf_in;
            closed_ff <= closed_in;
         end
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/byte_stream_tokenizer_unit.sv
`timescale 1ns / 1ps
// Latency: a byte's classified word is registered in the queue, and its result
// in the output buffer, before that result is valid on rsp.
// Throughput: one word per cycle unless the queue is full; a two-result word
// holds the output buffer until both are taken; a four-word queue absorbs that.
// Reset (synchronous): whitespace mode, delimiter length 1, delimiter ',',
// queue and output buffer empty, position state cleared.
// ----------------------------------------------------------------------------
// byte_stream_tokenizer_unit
// Splits a byte stream into (start, length) tokens by delimiter string,
// whitespace runs or CR/LF lines.
// ----------------------------------------------------------------------------
module byte_stream_tokenizer_unit import bst_pkg::*; #(
   parameter int POSITION_BITS   = POSITION_BITS_DEF,
   parameter int MAX_DELIM_BYTES = MAX_DELIM_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data
);

   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_empty;
   class_type push_word;
   class_type head_word;

   // front end: registers, window and classification
   bst_front #(
      .MAX_DELIM_BYTES(MAX_DELIM_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_word    (push_word)
   );

   // word queue
   bst_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .pop       (q_pop),
      .head_word (head_word),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back end: token state and results
   bst_back #(
      .POSITION_BITS(POSITION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_word    (head_word),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
